>>> design/content_length_deframer_defines.svh
// Assertion macros used by the deframer RTL.
`ifndef CONTENT_LENGTH_DEFRAMER_DEFINES_SVH
`define CONTENT_LENGTH_DEFRAMER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define CLD_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define CLD_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cld_pkg.sv
package cld_pkg;

  // Result status codes
  localparam logic [2:0] ST_BODY      = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_CLEAN_END = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  // Characters of interest
  localparam logic [7:0] CHR_CR    = 8'h0d;
  localparam logic [7:0] CHR_LF    = 8'h0a;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_PLUS  = 8'h2b;
  localparam logic [7:0] CHR_MINUS = 8'h2d;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  // Request from the message control to the header line parser
  typedef struct packed {
    logic       feed;
    logic       clear;
    logic [7:0] data;
  } hdr_cmd_t;

  // Summary of the header line seen so far
  typedef struct packed {
    logic has_bytes;
    logic key_ok;
    logic negative;
  } hdr_stat_t;

endpackage

>>> design/cld_in_if.sv
interface cld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

>>> design/cld_out_if.sv
interface cld_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] body_byte;
  logic       last_of_body;

  modport source (output valid, output status, output body_byte, output last_of_body,
                  input ready);
  modport sink   (input valid, input status, input body_byte, input last_of_body,
                  output ready);
endinterface

>>> design/cld_hdr.sv
module cld_hdr
  import cld_pkg::*;
#(
  parameter int LENGTH_BITS = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hdr_cmd_t               cmd,
  output hdr_stat_t              stat,
  output logic [LENGTH_BITS-1:0] value
);

  localparam logic [3:0] KEY_LEN = 4'd15;

  localparam logic [1:0] VP_SKIP   = 2'd0;
  localparam logic [1:0] VP_SIGN   = 2'd1;
  localparam logic [1:0] VP_DIGITS = 2'd2;
  localparam logic [1:0] VP_DONE   = 2'd3;

  // Lower-case header name, one character per match position
  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] c;
    begin
      case (pos)
        4'd0:    c = "c";
        4'd1:    c = "o";
        4'd2:    c = "n";
        4'd3:    c = "t";
        4'd4:    c = "e";
        4'd5:    c = "n";
        4'd6:    c = "t";
        4'd7:    c = "-";
        4'd8:    c = "l";
        4'd9:    c = "e";
        4'd10:   c = "n";
        4'd11:   c = "g";
        4'd12:   c = "t";
        4'd13:   c = "h";
        4'd14:   c = ":";
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

  logic [3:0]             match_position, match_position_next;
  logic                   name_mismatch, name_mismatch_next;
  logic [1:0]             value_phase, value_phase_next;
  logic                   value_negative, value_negative_next;
  logic [LENGTH_BITS-1:0] value_accumulator, value_accumulator_next;
  logic                   line_has_bytes, line_has_bytes_next;

  logic [LENGTH_BITS+3:0] times_ten;
  logic [LENGTH_BITS-1:0] acc_digit;
  logic [7:0]             lower;
  logic                   is_digit;

  // Multiply by ten, add the digit, saturate at the all-ones length
  assign times_ten = {1'b0, value_accumulator, 3'b000}
                   + {3'b000, value_accumulator, 1'b0}
                   + {{LENGTH_BITS{1'b0}}, cmd.data[3:0]};
  assign acc_digit = (|times_ten[LENGTH_BITS+3:LENGTH_BITS]) ? '1
                                                              : times_ten[LENGTH_BITS-1:0];

  assign is_digit = (cmd.data >= CHR_ZERO) && (cmd.data <= CHR_NINE);
  assign lower    = ((cmd.data >= "A") && (cmd.data <= "Z")) ? (cmd.data + 8'd32) : cmd.data;

  // Advance the name match and the value reader
  always_comb begin
    match_position_next    = match_position;
    name_mismatch_next     = name_mismatch;
    value_phase_next       = value_phase;
    value_negative_next    = value_negative;
    value_accumulator_next = value_accumulator;
    line_has_bytes_next    = line_has_bytes;
    if (cmd.clear) begin
      match_position_next    = '0;
      name_mismatch_next     = 1'b0;
      value_phase_next       = VP_SKIP;
      value_negative_next    = 1'b0;
      value_accumulator_next = '0;
      line_has_bytes_next    = 1'b0;
    end else if (cmd.feed) begin
      line_has_bytes_next = 1'b1;
      if (!name_mismatch) begin
        if (match_position != KEY_LEN) begin
          if (lower == key_char(match_position)) begin
            match_position_next = match_position + 4'd1;
          end else begin
            name_mismatch_next = 1'b1;
          end
        end else begin
          unique case (value_phase) inside
            VP_SKIP: begin
              if (cmd.data == CHR_SPACE || cmd.data == CHR_TAB) begin
                value_phase_next = VP_SKIP;
              end else if (cmd.data == CHR_PLUS) begin
                value_phase_next = VP_SIGN;
              end else if (cmd.data == CHR_MINUS) begin
                value_negative_next = 1'b1;
                value_phase_next    = VP_SIGN;
              end else if (is_digit) begin
                value_accumulator_next = acc_digit;
                value_phase_next       = VP_DIGITS;
              end else begin
                value_phase_next = VP_DONE;
              end
            end
            VP_SIGN, VP_DIGITS: begin
              if (is_digit) begin
                value_accumulator_next = acc_digit;
                value_phase_next       = VP_DIGITS;
              end else begin
                value_phase_next = VP_DONE;
              end
            end
            default: value_phase_next = VP_DONE;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_position    <= '0;
      name_mismatch     <= 1'b0;
      value_phase       <= VP_SKIP;
      value_negative    <= 1'b0;
      value_accumulator <= '0;
      line_has_bytes    <= 1'b0;
    end else begin
      match_position    <= match_position_next;
      name_mismatch     <= name_mismatch_next;
      value_phase       <= value_phase_next;
      value_negative    <= value_negative_next;
      value_accumulator <= value_accumulator_next;
      line_has_bytes    <= line_has_bytes_next;
    end
  end

  assign stat.has_bytes = line_has_bytes;
  assign stat.key_ok    = (match_position == KEY_LEN) && !name_mismatch;
  assign stat.negative  = value_negative;
  assign value          = value_accumulator;

endmodule

>>> design/content_length_deframer.sv
// Content-length deframer.
// rx carries one stream byte per request (in_byte), or an end mark
// (end_of_input set, in_byte ignored). Header lines end at CR, LF or CR LF;
// a "Content-Length:" header (any letter case) sets the body length, the
// last one winning, and a blank line opens the body.
// tx carries at most one result per request: each body byte with status 0
// and last_of_body on the final one, or a status of 1 (empty body), 2 (clean
// end), 3 (missing or negative length) or 4 (truncated). Header bytes give
// no result. Each end mark gives one result and returns to the reset state.
// A request is held in the input register; its result is then loaded into
// the result register. Throughput: one request per cycle while tx takes
// results; the per-byte state update is a single pass of logic between the
// two registers. Reset (rst, synchronous) empties both registers and starts
// at a header line. When tx stalls, the held result and one more request
// are buffered, then rx.ready drops until tx takes the held result.
`include "content_length_deframer_defines.svh"

module content_length_deframer
  import cld_pkg::*;
#(
  parameter int LENGTH_BITS = 31
) (
  input logic       clk,
  input logic       rst,
  cld_in_if.sink    rx,
  cld_out_if.source tx
);

  localparam logic [1:0] PH_LINE    = 2'd0;
  localparam logic [1:0] PH_CR      = 2'd1;
  localparam logic [1:0] PH_CR_BODY = 2'd2;
  localparam logic [1:0] PH_BODY    = 2'd3;

  // Input register
  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_eoi;
  logic       advance;

  // Result register
  logic       o_valid;
  logic [2:0] o_status;
  logic [7:0] o_byte;
  logic       o_last;

  // Message state
  logic [1:0]             phase, phase_next;
  logic                   length_known, length_known_next;
  logic                   length_negative, length_negative_next;
  logic [LENGTH_BITS-1:0] body_length, body_length_next;
  logic                   header_seen, header_seen_next;
  logic [LENGTH_BITS-1:0] body_remaining, body_remaining_next;

  hdr_cmd_t               cmd;
  hdr_stat_t              hstat;
  logic [LENGTH_BITS-1:0] hvalue;

  logic       line_len_ok;
  logic       line_neg;
  logic       eoi_seen;
  logic       eoi_known;
  logic       eoi_negative;
  logic [1:0] eff_phase;
  logic       swallow;
  logic       is_eol;
  logic       res_valid;
  logic [2:0] res_status;
  logic [7:0] res_byte;
  logic       res_last;

  cld_hdr #(.LENGTH_BITS(LENGTH_BITS)) u_hdr (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .stat  (hstat),
    .value (hvalue)
  );

  assign advance  = s_valid && (!o_valid || tx.ready);
  assign rx.ready = !s_valid || advance;

  // Hold the request until the result side can take its outcome
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (rx.ready) begin
      s_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s_byte <= rx.in_byte;
      s_eoi  <= rx.end_of_input;
    end
  end

  assign line_len_ok  = hstat.has_bytes && hstat.key_ok;
  assign line_neg     = hstat.negative && (|hvalue);
  assign eoi_seen     = header_seen || hstat.has_bytes;
  assign eoi_known    = length_known || line_len_ok;
  assign eoi_negative = line_len_ok ? line_neg : length_negative;
  assign is_eol       = (s_byte == CHR_CR) || (s_byte == CHR_LF);

  // Apply one request to the message state
  always_comb begin
    phase_next           = phase;
    length_known_next    = length_known;
    length_negative_next = length_negative;
    body_length_next     = body_length;
    header_seen_next     = header_seen;
    body_remaining_next  = body_remaining;
    cmd.feed             = 1'b0;
    cmd.clear            = 1'b0;
    cmd.data             = s_byte;
    res_valid            = 1'b0;
    res_status           = ST_BODY;
    res_byte             = 8'h00;
    res_last             = 1'b0;
    eff_phase            = phase;
    swallow              = 1'b0;
    if (advance) begin
      if (s_eoi) begin
        // End mark: report and return to reset
        res_valid = 1'b1;
        if (phase == PH_CR_BODY || phase == PH_BODY) begin
          res_status = ST_TRUNC;
        end else if (!eoi_seen) begin
          res_status = ST_CLEAN_END;
        end else if (!eoi_known || eoi_negative) begin
          res_status = ST_BAD_LEN;
        end else begin
          res_status = ST_TRUNC;
        end
        phase_next           = PH_LINE;
        length_known_next    = 1'b0;
        length_negative_next = 1'b0;
        body_length_next     = '0;
        header_seen_next     = 1'b0;
        body_remaining_next  = '0;
        cmd.clear            = 1'b1;
      end else begin
        // Swallow the LF of a CR LF pair
        unique case (phase)
          PH_CR: begin
            eff_phase = PH_LINE;
            swallow   = (s_byte == CHR_LF);
          end
          PH_CR_BODY: begin
            eff_phase = PH_BODY;
            swallow   = (s_byte == CHR_LF);
          end
          default: eff_phase = phase;
        endcase
        phase_next = eff_phase;
        if (!swallow) begin
          if (eff_phase == PH_BODY) begin
            // Pass a body byte, close the message on the last one
            res_valid = 1'b1;
            res_byte  = s_byte;
            if (body_remaining <= {{(LENGTH_BITS-1){1'b0}}, 1'b1}) begin
              res_last             = 1'b1;
              phase_next           = PH_LINE;
              length_known_next    = 1'b0;
              length_negative_next = 1'b0;
              body_length_next     = '0;
              header_seen_next     = 1'b0;
              body_remaining_next  = '0;
              cmd.clear            = 1'b1;
            end else begin
              body_remaining_next = body_remaining - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
            end
          end else if (is_eol) begin
            cmd.clear = 1'b1;
            if (hstat.has_bytes) begin
              // Close a header line
              if (hstat.key_ok) begin
                length_known_next    = 1'b1;
                length_negative_next = line_neg;
                body_length_next     = hvalue;
              end
              header_seen_next = 1'b1;
              phase_next       = (s_byte == CHR_CR) ? PH_CR : PH_LINE;
            end else if (!length_known || length_negative || body_length == '0) begin
              // Blank line with nothing to pass: report, start over
              res_valid            = 1'b1;
              res_status           = (!length_known || length_negative) ? ST_BAD_LEN
                                                                        : ST_EMPTY;
              phase_next           = (s_byte == CHR_CR) ? PH_CR : PH_LINE;
              length_known_next    = 1'b0;
              length_negative_next = 1'b0;
              body_length_next     = '0;
              header_seen_next     = 1'b0;
              body_remaining_next  = '0;
            end else begin
              // Blank line: open the body
              body_remaining_next = body_length;
              phase_next          = (s_byte == CHR_CR) ? PH_CR_BODY : PH_BODY;
            end
          end else begin
            cmd.feed = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LINE;
      length_known    <= 1'b0;
      length_negative <= 1'b0;
      body_length     <= '0;
      header_seen     <= 1'b0;
      body_remaining  <= '0;
    end else begin
      phase           <= phase_next;
      length_known    <= length_known_next;
      length_negative <= length_negative_next;
      body_length     <= body_length_next;
      header_seen     <= header_seen_next;
      body_remaining  <= body_remaining_next;
    end
  end

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= res_valid;
    end else if (tx.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      o_status <= res_status;
      o_byte   <= res_byte;
      o_last   <= res_last;
    end
  end

  assign tx.valid        = o_valid;
  assign tx.status       = o_status;
  assign tx.body_byte    = o_byte;
  assign tx.last_of_body = o_last;

  `CLD_ASSERT_NOW(a_status_clean, clk, rst, o_valid && (o_status != ST_BODY), (o_byte == 8'h00) && !o_last, "non-body result carries body data")
  `CLD_ASSERT_NOW(a_remaining_idle, clk, rst, (phase == PH_LINE) || (phase == PH_CR), body_remaining == '0, "body count left outside the body")
  `CLD_ASSERT_NOW(a_remaining_body, clk, rst, (phase == PH_BODY) || (phase == PH_CR_BODY), body_remaining != '0, "body phase with nothing left")
  `CLD_ASSERT_NEXT(a_eoi_reset, clk, rst, advance && s_eoi, (phase == PH_LINE) && !header_seen && !length_known && o_valid, "end mark did not reset the message")

endmodule
